>>> sv/bcd_conv_pkg.sv
package bcd_conv_pkg;

    // Field widths of the channels
    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int POSITION_W = 5;
    localparam int COUNT_W    = 5;

    // Parameter defaults
    localparam int BIN_WIDTH_DEF   = 64;
    localparam int DIGIT_COUNT_DEF = 20;

    // Digits above this value get 3 added before each shift
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd4;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new value, clear the digits
        logic step;      // one shift-and-add-3 step
        logic count;     // register the significant digit count
        logic shift_out; // a digit was transferred, move to the next
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic step_last; // current step is the final one
        logic emit_last; // digit on the output is the last one
    } dp_status_t;

endpackage

>>> sv/bcd_conv_in_if.sv
interface bcd_conv_in_if;
    logic                               valid;
    logic                               ready;
    logic [bcd_conv_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> sv/bcd_conv_out_if.sv
interface bcd_conv_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [bcd_conv_pkg::DIGIT_W-1:0]     digit;
    logic [bcd_conv_pkg::POSITION_W-1:0]  position;
    logic [bcd_conv_pkg::COUNT_W-1:0]     digit_count;
    logic                                 last_digit;

    modport source (output valid, output digit, output position, output digit_count,
                    output last_digit, input ready);
    modport sink   (input valid, input digit, input position, input digit_count,
                    input last_digit, output ready);
endinterface

>>> sv/bcd_conv_ctrl.sv
module bcd_conv_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  bcd_conv_pkg::dp_status_t  sts,
    output bcd_conv_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/bcd_conv_dp.sv
module bcd_conv_dp #(
    parameter int BIN_WIDTH   = bcd_conv_pkg::BIN_WIDTH_DEF,
    parameter int DIGIT_COUNT = bcd_conv_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bcd_conv_pkg::ctrl_cmd_t               cmd,
    output bcd_conv_pkg::dp_status_t              sts,
    input  logic [bcd_conv_pkg::VALUE_W-1:0]      value,
    output logic [bcd_conv_pkg::DIGIT_W-1:0]      digit,
    output logic [bcd_conv_pkg::POSITION_W-1:0]   position,
    output logic [bcd_conv_pkg::COUNT_W-1:0]      digit_count,
    output logic                                  last_digit
);

    localparam int STEP_W  = $clog2(BIN_WIDTH);
    localparam int DIGIT_W = bcd_conv_pkg::DIGIT_W;
    localparam int COUNT_W = bcd_conv_pkg::COUNT_W;
    localparam int POS_W   = bcd_conv_pkg::POSITION_W;

    logic [BIN_WIDTH-1:0] bin_reg;
    logic [BIN_WIDTH-1:0] bin_next;
    logic [DIGIT_W-1:0]   bcd_reg  [DIGIT_COUNT];
    logic [DIGIT_W-1:0]   bcd_next [DIGIT_COUNT];
    logic [DIGIT_W-1:0]   adj      [DIGIT_COUNT];
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic [COUNT_W-1:0]   sig_count;

    // Add 3 to every digit above 4
    always_comb
    begin
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (bcd_reg[d] > bcd_conv_pkg::DABBLE_LIMIT)
            begin
                adj[d] = bcd_reg[d] + bcd_conv_pkg::DABBLE_ADD;
            end
            else
            begin
                adj[d] = bcd_reg[d];
            end
        end
    end

    // Index of the highest nonzero digit, plus one
    always_comb
    begin
        sig_count = '0;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (bcd_reg[d] != '0)
            begin
                sig_count = COUNT_W'(d + 1);
            end
        end
    end

    // Binary and digit chain: load, shift left while converting, shift right while emitting
    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        priority if (cmd.load)
        begin
            bin_next = value[BIN_WIDTH-1:0];
            for (int d = 0; d < DIGIT_COUNT; d++)
            begin
                bcd_next[d] = '0;
            end
        end
        else if (cmd.step)
        begin
            bin_next    = {bin_reg[BIN_WIDTH-2:0], 1'b0};
            bcd_next[0] = {adj[0][DIGIT_W-2:0], bin_reg[BIN_WIDTH-1]};
            for (int d = 1; d < DIGIT_COUNT; d++)
            begin
                bcd_next[d] = {adj[d][DIGIT_W-2:0], adj[d-1][DIGIT_W-1]};
            end
        end
        else if (cmd.count)
        begin
            count_next = sig_count;
        end
        else if (cmd.shift_out)
        begin
            for (int d = 0; d < DIGIT_COUNT - 1; d++)
            begin
                bcd_next[d] = bcd_reg[d+1];
            end
            bcd_next[DIGIT_COUNT-1] = '0;
        end
    end

    // Step, position and remaining-digit counters
    always_comb
    begin
        step_next = step_reg;
        pos_next  = pos_reg;
        rem_next  = rem_reg;
        if (cmd.load)
        begin
            step_next = '0;
        end
        if (cmd.step)
        begin
            step_next = step_reg + STEP_W'(1);
        end
        if (cmd.count)
        begin
            pos_next = '0;
            rem_next = (sig_count == '0) ? COUNT_W'(1) : sig_count;
        end
        if (cmd.shift_out)
        begin
            pos_next = pos_reg + POS_W'(1);
            rem_next = rem_reg - COUNT_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        count_reg <= count_next;
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            pos_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            pos_reg  <= pos_next;
            rem_reg  <= rem_next;
        end
    end

    assign sts.step_last = (step_reg == STEP_W'(BIN_WIDTH - 1));
    assign sts.emit_last = (rem_reg == COUNT_W'(1));

    assign digit       = bcd_reg[0];
    assign position    = pos_reg;
    assign digit_count = count_reg;
    assign last_digit  = sts.emit_last;

endmodule

>>> sv/binary_to_bcd_converter.sv
// Double dabble binary to BCD converter, digits emitted least significant first.
// Per input: conversion steps (ST_CONV), digit count (ST_COUNT), then digits out (ST_EMIT).
// A new value is taken only when idle, after the last of N = max(digits, 1) digits is out;
// the BIN_WIDTH shift-and-add-3 steps use the single digit chain; out_ready may stall digits.
// Reset: rst_n clears the controller and counters at once; the block is then idle.
module binary_to_bcd_converter #(
    parameter int BIN_WIDTH   = bcd_conv_pkg::BIN_WIDTH_DEF,
    parameter int DIGIT_COUNT = bcd_conv_pkg::DIGIT_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bcd_conv_in_if.sink   bin_in,
    bcd_conv_out_if.source bcd_out
);

    bcd_conv_pkg::ctrl_cmd_t  cmd;
    bcd_conv_pkg::dp_status_t sts;

    // Sequencer
    bcd_conv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bin_in.valid),
        .in_ready  (bin_in.ready),
        .out_valid (bcd_out.valid),
        .out_ready (bcd_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Shift registers and counters
    bcd_conv_dp #(
        .BIN_WIDTH   (BIN_WIDTH),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .value       (bin_in.value),
        .digit       (bcd_out.digit),
        .position    (bcd_out.position),
        .digit_count (bcd_out.digit_count),
        .last_digit  (bcd_out.last_digit)
    );

endmodule
